[design/sq30alu_pkg.sv]
// shared constants and types for the saturating q30 fixed-point alu
`default_nettype none

package sq30alu_pkg;

    // fixed-point format
    localparam int FRAC_BITS = 30;
    localparam logic signed [31:0] FX_MAX = 32'sh3FFF_FFFF;
    localparam logic signed [31:0] FX_MIN = 32'shC000_0000;

    // operation codes carried by the kind field
    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_F2X = 3'd3;
    localparam logic [2:0] KIND_X2F = 3'd4;

    // single float field constants
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;
    localparam logic [7:0] EXP_ONE     = 8'd127;
    localparam logic [7:0] EXP_F2X_TOP = 8'd126;
    localparam logic [7:0] EXP_X2F_OFS = 8'd97;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_stage_en;

endpackage

`default_nettype wire

[design/sq30alu_ctl.sv]
// valid tracking and stall propagation for the three-stage pipeline
`default_nettype none

module sq30alu_ctl
    import sq30alu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire logic      i_stall,
    output logic           o_stall,
    output logic           o_valid,
    output t_stage_en      o_en
);

    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    logic en1, en2, en3;

    // a stage loads when it is empty or its contents move on
    assign en3 = !r_v3 || !i_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    // next valid bits
    always_comb begin
        n_v1 = en1 ? i_valid : r_v1;
        n_v2 = en2 ? r_v1 : r_v2;
        n_v3 = en3 ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    assign o_stall  = !en1;
    assign o_valid  = r_v3;
    assign o_en.en1 = en1;
    assign o_en.en2 = en2;
    assign o_en.en3 = en3;

endmodule

`default_nettype wire

[design/saturating_q30_fixed_point_alu.sv]
// top level of the saturating q30 fixed-point alu
`default_nettype none

// Three-stage pipeline: one item may enter every cycle while o_stall is
// low, and its result passes through the stage 1, 2 and 3 registers.
// Stage 1 holds the 32x32 signed product and the 33-bit sum or
// difference, stage 2 saturates them, converts single float to fixed and
// finds the leading one of |a|, stage 3 normalizes and rounds the fixed to
// float conversion into the output register. A stall on the output holds
// the whole pipe only once every stage is full; bubbles are squeezed out.

module saturating_q30_fixed_point_alu
    import sq30alu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_kind,
    input  wire logic signed [31:0] i_operand_a,
    input  wire logic signed [31:0] i_operand_b,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_result
);

    t_stage_en en;

    sq30alu_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_en    (en)
    );

    // ---------------- stage 1 ----------------
    logic [2:0]         r_kind1;
    logic [31:0]        r_a1;
    logic signed [32:0] r_sum1, n_sum1;
    logic signed [63:0] r_prod1, n_prod1;
    logic               r_minmin1;
    logic [31:0]        r_mag1, n_mag1;

    // sum or difference, product and magnitude
    always_comb begin
        if (i_kind == KIND_SUB) begin
            n_sum1 = 33'(i_operand_a) - 33'(i_operand_b);
        end else begin
            n_sum1 = 33'(i_operand_a) + 33'(i_operand_b);
        end
        n_prod1 = 64'(i_operand_a) * 64'(i_operand_b);
        n_mag1  = i_operand_a[31] ? (~i_operand_a + 32'd1) : i_operand_a;
    end

    always_ff @(posedge i_clk) begin
        if (en.en1) begin
            r_kind1   <= i_kind;
            r_a1      <= i_operand_a;
            r_sum1    <= n_sum1;
            r_prod1   <= n_prod1;
            r_minmin1 <= (i_operand_a == FX_MIN) && (i_operand_b == FX_MIN);
            r_mag1    <= n_mag1;
        end
    end

    // ---------------- stage 2 ----------------
    logic [2:0]         r_kind2;
    logic [31:0]        r_res2, n_res2;
    logic               r_sign2;
    logic [31:0]        r_mag2;
    logic [4:0]         r_lead2, n_lead2;
    logic               r_zero2;

    logic signed [31:0] sum_sat, mul_sat, f2x_res;
    logic signed [33:0] prod_sh;
    logic [7:0]         f_exp, e_eff;
    logic [22:0]        f_frac;
    logic [23:0]        f_man;
    logic [6:0]         f_shamt;
    logic [29:0]        f_mag;

    // saturate add/sub and the shifted product
    always_comb begin
        if (r_sum1 < 33'(FX_MIN)) begin
            sum_sat = FX_MIN;
        end else if (r_sum1 > 33'(FX_MAX)) begin
            sum_sat = FX_MAX;
        end else begin
            sum_sat = r_sum1[31:0];
        end
        prod_sh = r_prod1[63:FRAC_BITS];
        if (r_minmin1) begin
            mul_sat = FX_MAX;
        end else if (prod_sh < 34'(FX_MIN)) begin
            mul_sat = FX_MIN;
        end else if (prod_sh > 34'(FX_MAX)) begin
            mul_sat = FX_MAX;
        end else begin
            mul_sat = prod_sh[31:0];
        end
    end

    // single float to fixed, truncating toward zero
    always_comb begin
        f_exp   = r_a1[30:23];
        f_frac  = r_a1[22:0];
        e_eff   = (f_exp == 8'd0) ? 8'd1 : f_exp;
        f_man   = {(f_exp != 8'd0), f_frac};
        f_shamt = 7'(EXP_F2X_TOP - e_eff);
        f_mag   = {f_man, 6'b0} >> f_shamt;
        if (f_exp == EXP_SPECIAL) begin
            if (f_frac != 23'd0) begin
                f2x_res = '0;
            end else begin
                f2x_res = r_a1[31] ? FX_MIN : FX_MAX;
            end
        end else if (f_exp >= EXP_ONE) begin
            f2x_res = r_a1[31] ? FX_MIN : FX_MAX;
        end else if (r_a1[31]) begin
            f2x_res = -$signed({2'b00, f_mag});
        end else begin
            f2x_res = $signed({2'b00, f_mag});
        end
    end

    // leading one of the magnitude
    always_comb begin
        n_lead2 = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_mag1[i]) begin
                n_lead2 = 5'(i);
            end
        end
    end

    // result select for everything but fixed to float
    always_comb begin
        case (r_kind1)
            KIND_ADD: n_res2 = sum_sat;
            KIND_SUB: n_res2 = sum_sat;
            KIND_MUL: n_res2 = mul_sat;
            KIND_F2X: n_res2 = f2x_res;
            default:  n_res2 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en.en2) begin
            r_kind2 <= r_kind1;
            r_res2  <= n_res2;
            r_sign2 <= r_a1[31];
            r_mag2  <= r_mag1;
            r_lead2 <= n_lead2;
            r_zero2 <= (r_mag1 == 32'd0);
        end
    end

    // ---------------- stage 3 ----------------
    logic [31:0] r_res3, n_res3;
    logic [31:0] norm;
    logic [24:0] keep_r;
    logic        round_up;
    logic [7:0]  x_exp;
    logic [22:0] x_man;
    logic [31:0] x2f_res;

    // normalize, round to nearest even, pack
    always_comb begin
        norm     = r_mag2 << (5'd31 - r_lead2);
        round_up = norm[7] && ((|norm[6:0]) || norm[8]);
        keep_r   = {1'b0, norm[31:8]} + {24'd0, round_up};
        if (keep_r[24]) begin
            x_exp = {3'b000, r_lead2} + EXP_X2F_OFS + 8'd1;
            x_man = '0;
        end else begin
            x_exp = {3'b000, r_lead2} + EXP_X2F_OFS;
            x_man = keep_r[22:0];
        end
        x2f_res = r_zero2 ? 32'd0 : {r_sign2, x_exp, x_man};
        n_res3  = (r_kind2 == KIND_X2F) ? x2f_res : r_res2;
    end

    always_ff @(posedge i_clk) begin
        if (en.en3) begin
            r_res3 <= n_res3;
        end
    end

    assign o_result = r_res3;

endmodule

`default_nettype wire

[design/sq30alu_chk.sv]
// port-level checker for the saturating q30 fixed-point alu
`default_nettype none

module sq30alu_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [2:0]  i_kind,
    input wire logic [31:0] i_operand_a,
    input wire logic [31:0] i_operand_b,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_result
);

    // a waiting result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    // input back-pressure only when the output is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");

    // an accepted item reaches the output when the output is not stalled meanwhile
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted item did not arrive");

    // pipe is empty right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

endmodule

bind saturating_q30_fixed_point_alu sq30alu_chk u_chk (.*);

`default_nettype wire

[bench/saturating_q30_fixed_point_alu_test.sv]
// self-checking bench for the saturating q30 fixed-point alu
`default_nettype none

module saturating_q30_fixed_point_alu_test;
    import sq30alu_pkg::*;

    localparam int RANDOM_OPS   = 650;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [2:0]         kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_alu_op;

    typedef struct {
        t_alu_op            op;
        logic signed [31:0] result;
    } t_alu_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [2:0]         i_kind = KIND_ADD;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic signed [31:0] o_result;

    t_alu_op     op_queue[$];
    t_alu_result expected_results[$];
    t_alu_op     op_on_bus;
    t_alu_result pending_result;
    t_alu_result oldest_result;
    int          total_ops = 0;
    int          ops_accepted = 0;
    int          results_checked = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;

    saturating_q30_fixed_point_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result)
    );

    always #2 i_clk = ~i_clk;

    // saturate a wide value to the q30 range
    function automatic logic signed [31:0] clamp_q30(logic signed [63:0] v);
        if (v < FX_MIN) return FX_MIN;
        if (v > FX_MAX) return FX_MAX;
        return v[31:0];
    endfunction

    // single float bit pattern to q30, truncating toward zero
    function automatic logic signed [31:0] float_bits_to_q30(logic [31:0] w);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [31:0] mant;
        logic [31:0] mag;
        int          sh;
        neg = w[31];
        ex  = w[30:23];
        fr  = w[22:0];
        if (ex == EXP_SPECIAL) begin
            if (fr != '0) return '0;
            return neg ? FX_MIN : FX_MAX;
        end
        if (ex >= EXP_ONE) return neg ? FX_MIN : FX_MAX;
        // denormals use the smallest normal exponent without the hidden one
        if (ex == 8'd0) begin
            mant = {9'd0, fr};
            sh   = 1 - 120;
        end else begin
            mant = {9'd1, fr};
            sh   = int'(ex) - 120;
        end
        if (sh >= 0) mag = mant << sh;
        else if (-sh >= 24) mag = '0;
        else mag = mant >> (-sh);
        return neg ? (~mag + 32'd1) : mag;
    endfunction

    // q30 to single float bit pattern, round to nearest even
    function automatic logic [31:0] q30_to_float_bits(logic signed [31:0] v);
        logic [31:0] sign;
        logic [31:0] mag;
        logic [31:0] keep;
        logic [31:0] rem;
        logic [31:0] half;
        int          p;
        int          r;
        if (v == 0) return '0;
        sign = '0;
        mag  = v;
        if (v < 0) begin
            sign = 32'h8000_0000;
            mag  = -v;
        end
        p = 31;
        while (mag[p] == 1'b0) p--;
        if (p <= 23) begin
            keep = mag << (23 - p);
        end else begin
            r    = p - 23;
            keep = mag >> r;
            rem  = mag & ((32'd1 << r) - 32'd1);
            half = 32'd1 << (r - 1);
            if (rem > half || (rem == half && keep[0])) keep = keep + 32'd1;
            // rounding carried into a new leading bit
            if (keep == 32'h0100_0000) begin
                keep = keep >> 1;
                p    = p + 1;
            end
        end
        return sign | (32'(p + int'(EXP_X2F_OFS)) << 23) | (keep & 32'h007F_FFFF);
    endfunction

    // expected result of one item
    function automatic logic signed [31:0] predict_q30_result(t_alu_op op);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] prod;
        wa = op.a;
        wb = op.b;
        case (op.kind)
            KIND_ADD: return clamp_q30(wa + wb);
            KIND_SUB: return clamp_q30(wa - wb);
            KIND_MUL: begin
                if (op.a == FX_MIN && op.b == FX_MIN) return FX_MAX;
                prod = wa * wb;
                return clamp_q30(prod >>> FRAC_BITS);
            end
            KIND_F2X: return float_bits_to_q30(op.a);
            KIND_X2F: return q30_to_float_bits(op.a);
            default:  return '0;
        endcase
    endfunction

    // idle percentages per phase: sender-heavy, receiver-heavy, none
    function automatic int sender_idle_pct();
        int ph;
        ph = (total_ops == 0) ? 0 : (ops_accepted * 3) / total_ops;
        if (ph == 0) return 27;
        if (ph == 1) return 47;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        int ph;
        ph = (total_ops == 0) ? 0 : (ops_accepted * 3) / total_ops;
        if (ph == 0) return 47;
        if (ph == 1) return 27;
        return 0;
    endfunction

    task automatic add_op(logic [2:0] kind, logic signed [31:0] a, logic signed [31:0] b);
        t_alu_op op;
        op.kind = kind;
        op.a    = a;
        op.b    = b;
        op_queue.push_back(op);
    endtask

    // fixed operand: full range, q30 range, small values, edges, near one
    function automatic logic signed [31:0] rand_operand();
        logic [31:0] r;
        int          mode;
        r    = $urandom;
        mode = $urandom_range(9);
        case (mode)
            0, 1, 2, 3: return r;
            4, 5, 6:    return {r[30], r[30:0]};
            7:          return $signed(32'($urandom_range(2047))) - 32'sd1024;
            8: begin
                case ($urandom_range(7))
                    0: return FX_MAX;
                    1: return FX_MIN;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    4: return -32'sd1;
                    5: return 32'sh7FFF_FFFF;
                    6: return 32'sh8000_0000;
                    default: return 32'sh0000_8000;
                endcase
            end
            default: return 32'sh4000_0000 + $signed(32'($urandom_range(63))) - 32'sd32;
        endcase
    endfunction

    // float bit pattern weighted toward the exponents that matter
    function automatic logic [31:0] rand_float_bits();
        logic [31:0] r;
        int          mode;
        r    = $urandom;
        mode = $urandom_range(9);
        case (mode)
            0: return {r[31], EXP_SPECIAL, (r[0] ? r[22:0] : 23'd0)};
            1: return {r[31], 8'd0, (r[1] ? r[22:0] : 23'd0)};
            2: return r;
            default: return {r[31], 8'($urandom_range(130, 92)), r[22:0]};
        endcase
    endfunction

    // sender: one item on the bus, held while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pending_result.op     = op_on_bus;
                pending_result.result = predict_q30_result(op_on_bus);
                expected_results.push_back(pending_result);
                ops_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (op_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    op_on_bus   = op_queue.pop_front();
                    i_valid     <= 1'b1;
                    i_kind      <= op_on_bus.kind;
                    i_operand_a <= op_on_bus.a;
                    i_operand_b <= op_on_bus.b;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result %h with no item outstanding", $time, o_result);
                    mismatches++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    results_checked++;
                    if (o_result !== oldest_result.result) begin
                        $display("%0t: kind %0d a %h b %h expected %h actual %h", $time,
                                 oldest_result.op.kind, oldest_result.op.a,
                                 oldest_result.op.b, oldest_result.result, o_result);
                        mismatches++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < receiver_stall_pct());
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("saturating_q30_fixed_point_alu_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        // directed: saturation edges, multiply corners
        add_op(KIND_ADD, FX_MAX, FX_MAX);
        add_op(KIND_ADD, FX_MIN, FX_MIN);
        add_op(KIND_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_op(KIND_ADD, FX_MAX, -32'sd1);
        add_op(KIND_SUB, FX_MIN, 32'sd1);
        add_op(KIND_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF);
        add_op(KIND_SUB, FX_MAX, FX_MIN);
        add_op(KIND_MUL, FX_MIN, FX_MIN);
        add_op(KIND_MUL, 32'sh8000_0000, 32'sh8000_0000);
        add_op(KIND_MUL, -32'sd1, 32'sd1);
        add_op(KIND_MUL, FX_MAX, FX_MIN);
        add_op(KIND_MUL, 32'sh7FFF_FFFF, 32'sh8000_0000);
        // directed: float to fixed specials
        add_op(KIND_F2X, 32'sh7F80_0000, 32'sd0);
        add_op(KIND_F2X, 32'shFF80_0000, 32'sd0);
        add_op(KIND_F2X, 32'sh7FC0_0001, 32'sd0);
        add_op(KIND_F2X, 32'sh3F80_0000, 32'sd0);
        add_op(KIND_F2X, 32'shBF80_0000, 32'sd0);
        add_op(KIND_F2X, 32'shBF7F_FFFF, 32'sd0);
        add_op(KIND_F2X, 32'sh8000_0000, 32'sd0);
        add_op(KIND_F2X, 32'sh0000_0001, 32'sd0);
        // directed: fixed to float zero, extremes, tie and carry rounding
        add_op(KIND_X2F, 32'sd0, 32'sd0);
        add_op(KIND_X2F, 32'sh8000_0000, 32'sd0);
        add_op(KIND_X2F, 32'sh0200_0006, 32'sd0);
        add_op(KIND_X2F, 32'sh3FFF_FFFF, 32'sd0);
        for (int k = int'(KIND_X2F) + 1; k < 8; k++) begin
            add_op(3'(k), 32'sh7FFF_FFFF, 32'sh8000_0000);
        end

        // random: mostly defined kinds, a few unused ones
        for (int n = 0; n < RANDOM_OPS; n++) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 19) add_op(KIND_ADD, rand_operand(), rand_operand());
            else if (pick < 38) add_op(KIND_SUB, rand_operand(), rand_operand());
            else if (pick < 57) add_op(KIND_MUL, rand_operand(), rand_operand());
            else if (pick < 76) add_op(KIND_F2X, rand_float_bits(), $urandom);
            else if (pick < 95) add_op(KIND_X2F, rand_operand(), $urandom);
            else add_op(3'($urandom_range(7, int'(KIND_X2F) + 1)), $urandom, $urandom);
        end
        total_ops = op_queue.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < total_ops || expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d results over add, subtract, multiply, both float conversions",
                 results_checked);
        $display("and unused kinds, under sender-heavy, receiver-heavy and no idling");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("saturating_q30_fixed_point_alu_test OK");
        end else begin
            $display("saturating_q30_fixed_point_alu_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
